// ===== src/mhd_pkg.sv =====
`timescale 1ns / 1ps
package mhd_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BS_RD,
        ST_BS_WAIT,
        ST_BS_CMP,
        ST_BEST_RD,
        ST_BEST_WAIT,
        ST_BEST,
        ST_TOP_RD,
        ST_TOP_WAIT,
        ST_TOP_CHK,
        ST_POP_RD,
        ST_POP_WAIT,
        ST_POP_CHK,
        ST_PUSH,
        ST_OUT
    } mhd_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;      // latch input item
        logic bs_init;      // start binary search
        logic rd_mid;       // read lines mid and mid+1
        logic bs_step;      // narrow search range
        logic rd_lo;        // read line lo
        logic take_best;    // compute best value
        logic first_run;    // answer zero, empty stack
        logic rd_top;       // read top line
        logic pop;          // drop top line
        logic rd_pair;      // read top two lines
        logic mult;         // start dominance products
        logic push;         // write new line
        logic set_ovf;      // flag overflow
        logic load_out;     // fill output register
    } mhd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic first;
        logic empty;
        logic bs_done;
        logic slope_gt;
        logic slope_eq;
        logic icpt_gt;
        logic count_ge2;
        logic dominated;
        logic mult_done;
        logic full;
    } mhd_stat_t;

endpackage

// ===== src/monotone_hull_dp_step_unit.sv =====
`timescale 1ns / 1ps
// Lower envelope of lines for minimum queries, one result beat per input beat.
// Input channel: query_point, new_slope, first_item under in_valid/in_ready.
// Output channel: best_value, hull_overflow under out_valid/out_ready.
// One item is worked on at a time; in_ready is high only while the unit idles.
// The time from the accepting edge to out_valid grows with S, the number of
// binary search steps (about log2 of the line count), with T, the number of
// dominance tests, and with P, the number of lines they pop. A search step
// goes through the registered line memory; a dominance test forms its 64 by
// 32 bit products as two 32 by 32 bit halves. An item whose line is dropped
// by the slope check runs no dominance test, and a first item skips the
// search. The unit is idle again in the cycle after the result is loaded.
// The result sits in an output register, so the unit takes the next input
// beat while an earlier result still waits; if the receiver stalls with a new
// result ready, the unit holds it until the register empties.
// Reset empties the line stack and drops any pending result; the stack
// memory itself is not cleared and needs no clearing pass.
module monotone_hull_dp_step_unit
    import mhd_pkg::*;
#(
    parameter int HULL_DEPTH = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] query_point,
    input  logic [31:0] new_slope,
    input  logic        first_item,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [62:0] best_value,
    output logic        hull_overflow
);

    mhd_cmd_t  cmd;
    mhd_stat_t stat;

    mhd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    mhd_dp #(
        .HULL_DEPTH (HULL_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .query_point   (query_point),
        .new_slope     (new_slope),
        .first_item    (first_item),
        .cmd           (cmd),
        .stat          (stat),
        .best_value    (best_value),
        .hull_overflow (hull_overflow)
    );

endmodule

// ===== src/mhd_ctrl.sv =====
`timescale 1ns / 1ps
module mhd_ctrl
    import mhd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  mhd_stat_t stat,
    output mhd_cmd_t  cmd
);

    mhd_state_t state_reg, state_next;
    logic       ovalid_reg, ovalid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = ovalid_reg;

    always_comb
    begin
        state_next  = state_reg;
        ovalid_next = ovalid_reg;
        cmd         = '0;
        if (out_valid && out_ready)
        begin
            ovalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_BS_RD;
                end
            end
            ST_BS_RD:
            begin
                if (stat.first || stat.empty)
                begin
                    cmd.first_run = 1'b1;
                    state_next    = ST_TOP_RD;
                end
                else
                begin
                    cmd.bs_init = 1'b1;
                    state_next  = ST_BS_CMP;
                end
            end
            ST_BS_CMP:
            begin
                if (stat.bs_done)
                begin
                    cmd.rd_lo  = 1'b1;
                    state_next = ST_BEST_WAIT;
                end
                else
                begin
                    cmd.rd_mid = 1'b1;
                    state_next = ST_BS_WAIT;
                end
            end
            ST_BS_WAIT:
            begin
                state_next = ST_BEST_RD;
            end
            ST_BEST_RD:
            begin
                // Products of both lines are registered; compare now.
                cmd.bs_step = 1'b1;
                state_next  = ST_BS_CMP;
            end
            ST_BEST_WAIT:
            begin
                state_next = ST_BEST;
            end
            ST_BEST:
            begin
                cmd.take_best = 1'b1;
                state_next    = ST_TOP_RD;
            end
            ST_TOP_RD:
            begin
                if (stat.empty)
                begin
                    state_next = ST_POP_CHK;
                end
                else
                begin
                    cmd.rd_top = 1'b1;
                    state_next = ST_TOP_WAIT;
                end
            end
            ST_TOP_WAIT:
            begin
                state_next = ST_TOP_CHK;
            end
            ST_TOP_CHK:
            begin
                if (stat.slope_gt)
                begin
                    state_next = ST_OUT;
                end
                else if (stat.slope_eq && !stat.icpt_gt)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.pop    = stat.slope_eq;
                    state_next = ST_POP_CHK;
                end
            end
            ST_POP_CHK:
            begin
                if (stat.count_ge2)
                begin
                    cmd.rd_pair = 1'b1;
                    state_next  = ST_POP_RD;
                end
                else
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_POP_RD:
            begin
                state_next = ST_POP_WAIT;
            end
            ST_POP_WAIT:
            begin
                cmd.mult = 1'b1;
                if (stat.mult_done)
                begin
                    if (stat.dominated)
                    begin
                        cmd.pop    = 1'b1;
                        state_next = ST_POP_CHK;
                    end
                    else
                    begin
                        state_next = ST_PUSH;
                    end
                end
            end
            ST_PUSH:
            begin
                if (stat.full)
                begin
                    cmd.set_ovf = 1'b1;
                end
                else
                begin
                    cmd.push = 1'b1;
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!ovalid_next)
                begin
                    cmd.load_out = 1'b1;
                    ovalid_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == ST_IDLE))
        else $error("ready outside idle");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid)
        else $error("result not presented");
    a_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.push && cmd.pop))
        else $error("push and pop together");

endmodule

// ===== src/mhd_dp.sv =====
`timescale 1ns / 1ps
module mhd_dp
    import mhd_pkg::*;
#(
    parameter int HULL_DEPTH = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] query_point,
    input  logic [31:0] new_slope,
    input  logic        first_item,
    input  mhd_cmd_t    cmd,
    output mhd_stat_t   stat,
    output logic [62:0] best_value,
    output logic        hull_overflow
);

    localparam int AW = (HULL_DEPTH > 1) ? $clog2(HULL_DEPTH) : 1;
    localparam int CW = $clog2(HULL_DEPTH + 1);
    localparam logic [63:0] MAX63 = 64'h7FFF_FFFF_FFFF_FFFF;

    // Two copies so that two lines can be read in the same cycle.
    logic [95:0] mem_a [HULL_DEPTH];
    logic [95:0] mem_b [HULL_DEPTH];
    logic [95:0] rd_a_reg, rd_b_reg;
    logic [AW-1:0] addr_a, addr_b;

    logic [31:0] x_reg, s_reg;
    logic        first_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] lo_reg, hi_reg;
    logic [63:0] best_reg;
    logic [62:0] out_val_reg;
    logic        out_ovf_reg, ovf_reg;
    logic [64:0] va_reg, vb_reg;

    // Dominance test: 64x32 products split into two 32x32 halves over cycles.
    logic [1:0]  mph_reg;
    logic [63:0] m1_reg, m2_reg;
    logic [31:0] d1_reg, d2_reg;
    logic        n1_reg, n2_reg;
    logic [63:0] p1lo_reg, p1mid_reg, p2lo_reg, p2mid_reg;
    logic [CW-1:0] mid;

    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    always_comb
    begin
        addr_a = '0;
        addr_b = '0;
        if (cmd.rd_mid)
        begin
            addr_a = mid[AW-1:0];
            addr_b = AW'(mid + 1'b1);
        end
        else if (cmd.rd_lo)
        begin
            addr_a = lo_reg[AW-1:0];
        end
        else
        begin
            addr_a = AW'(count_reg - 2'd2);
            addr_b = AW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem_a[count_reg[AW-1:0]] <= {s_reg, best_reg};
            mem_b[count_reg[AW-1:0]] <= {s_reg, best_reg};
        end
        rd_a_reg <= mem_a[addr_a];
        rd_b_reg <= mem_b[addr_b];
    end

    logic [63:0] pa, pb;
    assign pa = {32'd0, rd_a_reg[95:64]} * {32'd0, x_reg};
    assign pb = {32'd0, rd_b_reg[95:64]} * {32'd0, x_reg};

    // Scaled differences: left = (c - b2)(a1 - s), right = (c - b1)(a2 - s).
    logic [95:0] p1, p2;
    logic        dom;
    assign p1 = {32'd0, p1lo_reg} + {p1mid_reg, 32'd0};
    assign p2 = {32'd0, p2lo_reg} + {p2mid_reg, 32'd0};
    always_comb
    begin
        logic nl, nr;
        nl = n1_reg && (p1 != '0);
        nr = n2_reg && (p2 != '0);
        if (nl != nr)
        begin
            dom = nl;
        end
        else if (nl)
        begin
            dom = (p1 >= p2);
        end
        else
        begin
            dom = (p1 <= p2);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            mph_reg   <= '0;
        end
        else
        begin
            if (cmd.first_run)
            begin
                count_reg <= '0;
            end
            else if (cmd.pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
            else if (cmd.push)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.mult && mph_reg != 2'd3)
            begin
                mph_reg <= mph_reg + 1'b1;
            end
            else
            begin
                mph_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            x_reg     <= query_point;
            s_reg     <= new_slope;
            first_reg <= first_item;
            ovf_reg   <= 1'b0;
        end
        if (cmd.first_run)
        begin
            best_reg <= '0;
        end
        if (cmd.bs_init)
        begin
            lo_reg <= '0;
            hi_reg <= count_reg - 1'b1;
        end
        va_reg <= {1'b0, pa} + {1'b0, rd_a_reg[63:0]};
        vb_reg <= {1'b0, pb} + {1'b0, rd_b_reg[63:0]};
        if (cmd.bs_step)
        begin
            if (va_reg > vb_reg)
            begin
                lo_reg <= mid + 1'b1;
            end
            else
            begin
                hi_reg <= mid;
            end
        end
        if (cmd.take_best)
        begin
            best_reg <= (va_reg > {1'b0, MAX63}) ? MAX63 : va_reg[63:0];
        end
        if (cmd.set_ovf)
        begin
            ovf_reg <= 1'b1;
        end
        if (cmd.mult)
        begin
            case (mph_reg)
                2'd0:
                begin
                    n1_reg <= best_reg < rd_b_reg[63:0];
                    m1_reg <= (best_reg >= rd_b_reg[63:0]) ? best_reg - rd_b_reg[63:0]
                                                           : rd_b_reg[63:0] - best_reg;
                    d1_reg <= rd_a_reg[95:64] - s_reg;
                    n2_reg <= best_reg < rd_a_reg[63:0];
                    m2_reg <= (best_reg >= rd_a_reg[63:0]) ? best_reg - rd_a_reg[63:0]
                                                           : rd_a_reg[63:0] - best_reg;
                    d2_reg <= rd_b_reg[95:64] - s_reg;
                end
                2'd1:
                begin
                    p1lo_reg <= {32'd0, m1_reg[31:0]} * {32'd0, d1_reg};
                    p2lo_reg <= {32'd0, m2_reg[31:0]} * {32'd0, d2_reg};
                end
                2'd2:
                begin
                    p1mid_reg <= {32'd0, m1_reg[63:32]} * {32'd0, d1_reg};
                    p2mid_reg <= {32'd0, m2_reg[63:32]} * {32'd0, d2_reg};
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.load_out)
        begin
            out_val_reg <= best_reg[62:0];
            out_ovf_reg <= ovf_reg;
        end
    end

    assign best_value    = out_val_reg;
    assign hull_overflow = out_ovf_reg;

    always_comb
    begin
        stat           = '0;
        stat.first     = first_reg;
        stat.empty     = (count_reg == '0);
        stat.bs_done   = !(lo_reg < hi_reg);
        stat.slope_gt  = s_reg > rd_b_reg[95:64];
        stat.slope_eq  = s_reg == rd_b_reg[95:64];
        stat.icpt_gt   = rd_b_reg[63:0] > best_reg;
        stat.count_ge2 = count_reg >= CW'(2);
        stat.dominated = dom;
        stat.mult_done = (mph_reg == 2'd3);
        stat.full      = count_reg >= CW'(HULL_DEPTH);
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(HULL_DEPTH))
        else $error("count above depth");
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> !stat.full)
        else $error("push on full stack");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> !stat.empty)
        else $error("pop on empty stack");

endmodule

// ===== tb/monotone_hull_dp_step_unit_test.sv =====
`timescale 1ns / 1ps
module monotone_hull_dp_step_unit_test;

    localparam int          DEPTH       = 8;
    localparam int          CYCLE_LIMIT = 2000000;
    localparam logic [62:0] MAX63       = {63{1'b1}};

    typedef struct {
        logic [62:0] best;
        logic        ovf;
    } envelope_answer_t;

    class hull_scoreboard #(int N = 8);
        logic [31:0]      slp [N];
        logic [63:0]      icp [N];
        int               cnt;
        envelope_answer_t pending[$];
        int               errors;
        int               checked;
        int               overflows;
        int               saturations;

        function new();
            cnt = 0;
            errors = 0;
            checked = 0;
            overflows = 0;
            saturations = 0;
        endfunction

        function logic [64:0] line_at(int j, logic [31:0] x);
            return {33'd0, slp[j]} * {33'd0, x} + {1'b0, icp[j]};
        endfunction

        // The top line is useless when the new line meets the one below it no
        // later than the top line does; cross-multiplied to stay exact.
        function bit top_useless(logic [31:0] s, logic [63:0] c);
            logic signed [97:0] lhs;
            logic signed [97:0] rhs;
            logic [31:0]        d1;
            logic [31:0]        d2;
            d1 = slp[cnt-2] - s;
            d2 = slp[cnt-1] - s;
            lhs = ($signed({34'd0, c}) - $signed({34'd0, icp[cnt-1]}))
                  * $signed({66'd0, d1});
            rhs = ($signed({34'd0, c}) - $signed({34'd0, icp[cnt-2]}))
                  * $signed({66'd0, d2});
            return lhs <= rhs;
        endfunction

        function void note_input(logic [31:0] x, logic [31:0] s, logic first);
            envelope_answer_t a;
            logic [64:0]      v;
            int               lo;
            int               hi;
            int               mid;
            bit               ins;
            a.best = '0;
            a.ovf = 1'b0;
            ins = 1;
            if (first || cnt == 0)
            begin
                cnt = 0;
            end
            else
            begin
                lo = 0;
                hi = cnt - 1;
                while (lo < hi)
                begin
                    mid = lo + (hi - lo) / 2;
                    if (line_at(mid, x) > line_at(mid + 1, x))
                        lo = mid + 1;
                    else
                        hi = mid;
                end
                v = line_at(lo, x);
                if (v > {2'b0, MAX63})
                begin
                    a.best = MAX63;
                    saturations++;
                end
                else
                begin
                    a.best = v[62:0];
                end
            end
            if (cnt > 0)
            begin
                if (s > slp[cnt-1])
                begin
                    ins = 0;
                end
                else if (s == slp[cnt-1])
                begin
                    if (icp[cnt-1] > {1'b0, a.best})
                        cnt--;
                    else
                        ins = 0;
                end
            end
            if (ins)
            begin
                while (cnt >= 2 && top_useless(s, {1'b0, a.best}))
                    cnt--;
                if (cnt >= N)
                begin
                    a.ovf = 1'b1;
                    overflows++;
                end
                else
                begin
                    slp[cnt] = s;
                    icp[cnt] = {1'b0, a.best};
                    cnt++;
                end
            end
            pending = {pending, a};
        endfunction

        function void check_result(logic [62:0] best, logic ovf);
            envelope_answer_t a;
            checked++;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: best=%0d ovf=%0b", best, ovf);
                return;
            end
            a = pending.pop_front();
            if (best !== a.best || ovf !== a.ovf)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: best exp %0d got %0d, ovf exp %0b got %0b",
                             a.best, best, a.ovf, ovf);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] query_point;
    logic [31:0] new_slope;
    logic        first_item;
    logic        out_valid;
    logic        out_ready;
    logic [62:0] best_value;
    logic        hull_overflow;

    hull_scoreboard #(DEPTH) sb;
    bit          no_idle;
    int          cycles;
    int          sent;
    logic [31:0] prev_slope;

    monotone_hull_dp_step_unit #(.HULL_DEPTH(DEPTH)) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .query_point  (query_point),
        .new_slope    (new_slope),
        .first_item   (first_item),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .best_value   (best_value),
        .hull_overflow(hull_overflow)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: check at the edge, then choose whether to stall next cycle.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result(best_value, hull_overflow);
            out_ready <= no_idle || ($urandom_range(0, 99) >= 35);
        end
    end

    task automatic send_beat(logic [31:0] x, logic [31:0] s, logic f);
        int gap;
        if (!no_idle && $urandom_range(0, 99) < 35)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        query_point <= x;
        new_slope <= s;
        first_item <= f;
        do @(posedge clk); while (!in_ready);
        sb.note_input(x, s, f);
        sent++;
        prev_slope = s;
    endtask

    function automatic logic [31:0] pick_query();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(0, 255);
            2: return $urandom_range(0, 1 << 20);
            default: return $urandom() >> $urandom_range(0, 31);
        endcase
    endfunction

    function automatic logic [31:0] next_slope(logic [31:0] p);
        logic [31:0] step;
        case ($urandom_range(0, 9))
            0: return p + $urandom_range(1, 1000);  // out of order, ignored
            1: return p;
            2, 3: step = $urandom_range(0, 3);
            4, 5, 6: step = $urandom_range(0, 1 << 16);
            default: step = $urandom() >> $urandom_range(2, 12);
        endcase
        return (step > p) ? 32'd0 : p - step;
    endfunction

    task automatic run_sequence(int len);
        send_beat($urandom(), $urandom(), 1'b1);
        for (int i = 1; i < len; i++)
        begin
            if ($urandom_range(0, 49) == 0)
                send_beat($urandom(), $urandom(), $urandom_range(0, 1));
            else
                send_beat(pick_query(), next_slope(prev_slope), 1'b0);
        end
    endtask

    initial
    begin
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        query_point = '0;
        new_slope = '0;
        first_item = 1'b0;
        out_ready = 1'b0;
        no_idle = 0;
        cycles = 0;
        sent = 0;
        prev_slope = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Later item on an empty stack behaves as a first item.
        send_beat(32'hFFFF_FFFF, 32'd500, 1'b0);
        send_beat(32'd10, 32'd600, 1'b0);            // rising slope, dropped
        send_beat(32'd10, 32'd500, 1'b0);            // equal slope
        send_beat(32'd3, 32'd400, 1'b0);
        send_beat(32'd7, 32'd300, 1'b0);
        send_beat(32'd100, 32'd0, 1'b0);
        send_beat(32'd0, 32'd0, 1'b0);
        // Saturation: steep line queried at the far end.
        send_beat(32'h1234_5678, 32'hFFFF_FFFF, 1'b1);
        send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0);
        send_beat(32'hFFFF_FFFF, 32'hFFFF_FFF0, 1'b0);
        send_beat(32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
        send_beat(32'h0000_0001, 32'h0000_0000, 1'b0);
        // A convex run long enough to fill the small stack.
        send_beat(32'd0, 32'd1000, 1'b1);
        for (int i = 1; i <= 12; i++)
            send_beat(32'd50 * i, 32'd1000 - 32'd60 * i, 1'b0);

        while (sent < 1825)
        begin
            no_idle = (sent >= 800 && sent < 1100);
            run_sequence($urandom_range(1, 40));
        end
        no_idle = 0;
        in_valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("%0d beats sent, %0d results checked, %0d overflows, %0d saturated",
                 sent, sb.checked, sb.overflows, sb.saturations);
        $display("stack depth %0d, %0d mismatches", DEPTH, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
src/mhd_pkg.sv
src/mhd_ctrl.sv
src/mhd_dp.sv
src/monotone_hull_dp_step_unit.sv
tb/monotone_hull_dp_step_unit_test.sv
